[hdl/kcc_pkg.sv]
// ----------------------------------------------------------------------------
// Keyboard command controller package
// Item types, command group codes and reply constants.
// ----------------------------------------------------------------------------
package kcc_pkg;

   typedef struct packed {
      logic       opcode;
      logic [7:0] data_byte;
      logic       shift_held;
      logic       ctrl_held;
      logic       graph_held;
   } req_type;

   typedef struct packed {
      logic [7:0] reply_byte;
      logic       clear_first;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      RUN_SINGLE = 2'd0,
      RUN_LED    = 2'd1,
      RUN_SWITCH = 2'd2
   } run_kind_type;

   // one queued reply run
   typedef struct packed {
      run_kind_type kind;
      logic [7:0]   data;
      logic         clear;
   } run_type;

   localparam logic       OP_COMMAND = 1'b0;
   localparam logic       OP_RELEASE = 1'b1;

   localparam logic [2:0] GRP_RPT_TIME_0 = 3'b000;
   localparam logic [2:0] GRP_RPT_TIME_1 = 3'b001;
   localparam logic [2:0] GRP_LED_SET    = 3'b010;
   localparam logic [2:0] GRP_LED_READ   = 3'b011;
   localparam logic [2:0] GRP_SW_READ    = 3'b100;
   localparam logic [2:0] GRP_RPT_CTRL   = 3'b101;
   localparam logic [2:0] GRP_ENABLE     = 3'b110;
   localparam logic [2:0] GRP_RESET      = 3'b111;

   localparam logic [7:0] KEY_SHIFT = 8'h10;
   localparam logic [7:0] KEY_CTRL  = 8'h11;
   localparam logic [7:0] KEY_GRAPH = 8'h12;

   localparam logic [7:0] BRK_SHIFT = 8'h86;
   localparam logic [7:0] BRK_CTRL  = 8'h8a;
   localparam logic [7:0] BRK_GRAPH = 8'h8c;
   localparam logic [7:0] DIAG_OK   = 8'h00;

   localparam logic [7:0] LED_BASE = 8'hc0;
   localparam logic [7:0] SW_BASE  = 8'h80;

   localparam int         SW_SHIFT_POS = 3;
   localparam int         SW_CTRL_POS  = 5;
   localparam int         SW_GRAPH_POS = 6;

   localparam int         RUN_BYTES = 8;

endpackage

[hdl/kcc_front.sv]
// ----------------------------------------------------------------------------
// Keyboard command controller front end
// Decodes items, keeps LED, repeat and enable state, queues reply runs.
// ----------------------------------------------------------------------------
module kcc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  kcc_pkg::req_type  item,
   output logic              push,
   output kcc_pkg::run_type  run
);

   logic [7:0] led_ff,     led_in;
   logic       repeat_ff,  repeat_in;
   logic       enable_ff,  enable_in;
   logic       has_run;
   logic [2:0] pos;
   logic       b0;
   logic [7:0] sw_bits;

   always_comb begin
      led_in    = led_ff;
      repeat_in = repeat_ff;
      enable_in = enable_ff;
      has_run   = 1'b0;
      run.kind  = kcc_pkg::RUN_SINGLE;
      run.data  = kcc_pkg::DIAG_OK;
      run.clear = 1'b0;
      pos       = item.data_byte[3:1];
      b0        = item.data_byte[0];
      sw_bits   = '0;
      sw_bits[kcc_pkg::SW_SHIFT_POS] = item.shift_held;
      sw_bits[kcc_pkg::SW_CTRL_POS]  = item.ctrl_held;
      sw_bits[kcc_pkg::SW_GRAPH_POS] = item.graph_held;
      if (item.opcode == kcc_pkg::OP_RELEASE) begin
         if (enable_ff) begin
            case (item.data_byte)
               kcc_pkg::KEY_SHIFT: begin
                  has_run  = 1'b1;
                  run.data = kcc_pkg::BRK_SHIFT;
               end
               kcc_pkg::KEY_CTRL: begin
                  has_run  = 1'b1;
                  run.data = kcc_pkg::BRK_CTRL;
               end
               kcc_pkg::KEY_GRAPH: begin
                  has_run  = 1'b1;
                  run.data = kcc_pkg::BRK_GRAPH;
               end
               default: has_run = 1'b0;
            endcase
         end
      end else begin
         case (item.data_byte[7:5])
            kcc_pkg::GRP_RPT_CTRL: repeat_in = b0;
            kcc_pkg::GRP_LED_SET:  led_in[pos] = b0;
            kcc_pkg::GRP_LED_READ: begin
               has_run   = 1'b1;
               run.kind  = kcc_pkg::RUN_LED;
               run.data  = led_ff;
               run.clear = 1'b1;
            end
            kcc_pkg::GRP_SW_READ: begin
               has_run   = 1'b1;
               run.kind  = kcc_pkg::RUN_SWITCH;
               run.data  = sw_bits;
               run.clear = 1'b1;
            end
            kcc_pkg::GRP_ENABLE: enable_in = b0;
            kcc_pkg::GRP_RESET: begin
               led_in    = '0;
               repeat_in = 1'b1;
               enable_in = 1'b1;
               has_run   = ~b0;
               run.clear = 1'b1;
            end
            default: has_run = 1'b0;
         endcase
      end
   end

   assign push = accept & has_run;

   always_ff @(posedge clock) begin
      if (reset) begin
         led_ff    <= '0;
         repeat_ff <= 1'b1;
         enable_ff <= 1'b1;
      end else if (accept) begin
         led_ff    <= led_in;
         repeat_ff <= repeat_in;
         enable_ff <= enable_in;
      end
   end

endmodule

[hdl/kcc_queue.sv]
// ----------------------------------------------------------------------------
// Keyboard command controller run queue
// Two-entry queue of reply runs between front end and back end.
// ----------------------------------------------------------------------------
module kcc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  kcc_pkg::run_type  push_run,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output kcc_pkg::run_type  head_run
);

   kcc_pkg::run_type mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;

   assign full       = count_ff[1];
   assign head_valid = (count_ff != 2'd0);
   assign head_run   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_run;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hdl/kcc_back.sv]
// ----------------------------------------------------------------------------
// Keyboard command controller back end
// Queued runs go one byte per cycle into the output register unless stalled.
// ----------------------------------------------------------------------------
module kcc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  kcc_pkg::run_type  head_run,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output kcc_pkg::rsp_type  rsp_item
);

   logic [2:0]       idx_ff, idx_in;
   logic             out_valid_ff, out_valid_in;
   kcc_pkg::rsp_type out_item_ff;
   kcc_pkg::rsp_type gen;
   logic             load;
   logic             run_end;

   always_comb begin
      run_end = (idx_ff == 3'(kcc_pkg::RUN_BYTES - 1));
      case (head_run.kind)
         kcc_pkg::RUN_LED: begin
            gen.reply_byte  = kcc_pkg::LED_BASE | {4'd0, idx_ff, head_run.data[idx_ff]};
            gen.clear_first = (idx_ff == 3'd0);
            gen.last        = run_end;
         end
         kcc_pkg::RUN_SWITCH: begin
            gen.reply_byte  = kcc_pkg::SW_BASE | {4'd0, idx_ff, head_run.data[idx_ff]};
            gen.clear_first = (idx_ff == 3'd0);
            gen.last        = run_end;
         end
         default: begin
            gen.reply_byte  = head_run.data;
            gen.clear_first = head_run.clear;
            gen.last        = 1'b1;
         end
      endcase
   end

   always_comb begin
      load         = head_valid & (~out_valid_ff | ~rsp_stall);
      pop          = load & gen.last;
      out_valid_in = out_valid_ff;
      idx_in       = idx_ff;
      if (~out_valid_ff | ~rsp_stall) begin
         out_valid_in = head_valid;
      end
      if (load) begin
         idx_in = gen.last ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_item_ff <= gen;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

[hdl/keyboard_command_controller.sv]
// ----------------------------------------------------------------------------
// Keyboard command controller
// Serial keyboard command decoder and reply byte generator.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries a host command byte or a key release event with the
//   live shift, ctrl and graph levels. rsp_ channel returns reply bytes; last
//   marks the final byte of one item's run, clear_first the queue flush.
//   Items with no reply produce nothing on rsp_.
// Order: the first reply byte of an item passes through the run queue and
//   then the output register before it is presented on rsp_.
// Throughput: one reply byte per cycle from the output register while
//   rsp_stall is low; LED and switch reads give 8 bytes, single byte replies
//   1 byte. The back end sequencer steps a 3-bit byte index through a run.
// A two-entry run queue separates decode from reply generation; req_stall is
//   high while that queue is full.
// Reset: LED bits cleared, repeat and key enable set, queue and output
//   register emptied.
// Receiver stall: the output byte holds; the queue fills, then req_stall
//   rises.
// ----------------------------------------------------------------------------
module keyboard_command_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  kcc_pkg::req_type  req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output kcc_pkg::rsp_type  rsp_item
);

   logic             accept;
   logic             push;
   logic             pop;
   logic             full;
   logic             head_valid;
   kcc_pkg::run_type push_run;
   kcc_pkg::run_type head_run;

   assign req_stall = full;
   assign accept    = req_valid & ~full;

   kcc_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (req_item),
      .push   (push),
      .run    (push_run)
   );

   kcc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_run   (push_run),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_run   (head_run)
   );

   kcc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_run   (head_run),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

endmodule

[test/keyboard_command_controller_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keyboard command controller checker
// Watches both channels, tracks the LED, repeat and enable state from each
// accepted item, and compares every reply byte in order against the bytes
// that the item owes the host.
// ----------------------------------------------------------------------------
module keyboard_command_controller_check (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  kcc_pkg::req_type req_item,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  kcc_pkg::rsp_type rsp_item,
   output int               error_count,
   output int               owed_count,
   output int               accepted_items,
   output int               checked_replies
);

   logic [7:0]       led_bits;
   logic             repeat_on;
   logic             keys_enabled;
   kcc_pkg::rsp_type owed_reply_bytes [$];

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("mismatch at reply %0d: %s got %h expected %h",
               checked_replies, what, got, want);
      error_count++;
   endtask

   task automatic report_unexpected(input kcc_pkg::rsp_type got);
      $display("unexpected reply byte %h clear_first %b last %b",
               got.reply_byte, got.clear_first, got.last);
      error_count++;
   endtask

   task automatic predict_reply_bytes(input kcc_pkg::req_type item);
      logic [7:0]       bytes  [8];
      logic             clears [8];
      logic [7:0]       value;
      kcc_pkg::rsp_type reply;
      int               count;
      int               i;
      count = 0;
      if (item.opcode == kcc_pkg::OP_RELEASE) begin
         if (keys_enabled) begin
            case (item.data_byte)
               kcc_pkg::KEY_SHIFT: begin
                  bytes[0]  = kcc_pkg::BRK_SHIFT;
                  clears[0] = 1'b0;
                  count     = 1;
               end
               kcc_pkg::KEY_CTRL: begin
                  bytes[0]  = kcc_pkg::BRK_CTRL;
                  clears[0] = 1'b0;
                  count     = 1;
               end
               kcc_pkg::KEY_GRAPH: begin
                  bytes[0]  = kcc_pkg::BRK_GRAPH;
                  clears[0] = 1'b0;
                  count     = 1;
               end
               default: ;
            endcase
         end
      end else begin
         case (item.data_byte[7:5])
            kcc_pkg::GRP_RPT_CTRL: repeat_on = item.data_byte[0];
            kcc_pkg::GRP_LED_SET:  led_bits[item.data_byte[3:1]] = item.data_byte[0];
            kcc_pkg::GRP_LED_READ: begin
               for (i = 0; i < kcc_pkg::RUN_BYTES; i++) begin
                  value = kcc_pkg::LED_BASE | 8'(i << 1);
                  value[0] = led_bits[i];
                  bytes[i] = value;
                  clears[i] = (i == 0);
               end
               count = kcc_pkg::RUN_BYTES;
            end
            kcc_pkg::GRP_SW_READ: begin
               for (i = 0; i < kcc_pkg::RUN_BYTES; i++) begin
                  value = kcc_pkg::SW_BASE | 8'(i << 1);
                  if (i == kcc_pkg::SW_SHIFT_POS) value[0] = item.shift_held;
                  if (i == kcc_pkg::SW_CTRL_POS)  value[0] = item.ctrl_held;
                  if (i == kcc_pkg::SW_GRAPH_POS) value[0] = item.graph_held;
                  bytes[i] = value;
                  clears[i] = (i == 0);
               end
               count = kcc_pkg::RUN_BYTES;
            end
            kcc_pkg::GRP_ENABLE: keys_enabled = item.data_byte[0];
            kcc_pkg::GRP_RESET: begin
               led_bits     = '0;
               repeat_on    = 1'b1;
               keys_enabled = 1'b1;
               if (!item.data_byte[0]) begin
                  bytes[0] = kcc_pkg::DIAG_OK;
                  clears[0] = 1'b1;
                  count = 1;
               end
            end
            default: ;
         endcase
      end
      for (i = 0; i < count; i++) begin
         reply.reply_byte  = bytes[i];
         reply.clear_first = clears[i];
         reply.last        = (i == count - 1);
         owed_reply_bytes.push_back(reply);
      end
   endtask

   always @(posedge clock) begin
      kcc_pkg::rsp_type want;
      if (reset) begin
         led_bits        = '0;
         repeat_on       = 1'b1;
         keys_enabled    = 1'b1;
         error_count     = 0;
         accepted_items  = 0;
         checked_replies = 0;
         owed_reply_bytes.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_reply_bytes.size() == 0) begin
               report_unexpected(rsp_item);
            end else begin
               want = owed_reply_bytes.pop_front();
               if (rsp_item.reply_byte !== want.reply_byte)
                  report_mismatch("reply_byte", rsp_item.reply_byte, want.reply_byte);
               if (rsp_item.clear_first !== want.clear_first)
                  report_mismatch("clear_first", 8'(rsp_item.clear_first),
                                  8'(want.clear_first));
               if (rsp_item.last !== want.last)
                  report_mismatch("last", 8'(rsp_item.last), 8'(want.last));
            end
            checked_replies++;
         end
         if (req_valid && !req_stall) begin
            predict_reply_bytes(req_item);
            accepted_items++;
         end
      end
      owed_count = owed_reply_bytes.size();
   end

endmodule

[test/keyboard_command_controller_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keyboard command controller testbench
// Drives directed commands and key releases, then random items under four
// idling mixes on the request and reply channels; the checker predicts and
// compares every reply byte.
// ----------------------------------------------------------------------------
module keyboard_command_controller_test;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   kcc_pkg::req_type req_item;
   logic             rsp_valid;
   logic             rsp_stall;
   kcc_pkg::rsp_type rsp_item;

   int error_count;
   int owed_count;
   int accepted_items;
   int checked_replies;
   int send_idle_pct;
   int rsp_stall_pct;
   int phase;
   int n;

   keyboard_command_controller uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   keyboard_command_controller_check u_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_item        (req_item),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_item        (rsp_item),
      .error_count     (error_count),
      .owed_count      (owed_count),
      .accepted_items  (accepted_items),
      .checked_replies (checked_replies)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   task automatic send_item(input logic op, input logic [7:0] data, input logic sh,
                            input logic ct, input logic gr);
      kcc_pkg::req_type item;
      item.opcode     = op;
      item.data_byte  = data;
      item.shift_held = sh;
      item.ctrl_held  = ct;
      item.graph_held = gr;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_random_item();
      logic [7:0] data;
      logic       op;
      if ($urandom_range(99) < 30) begin
         op = kcc_pkg::OP_RELEASE;
         if ($urandom_range(3) == 0) data = 8'($urandom_range(255));
         else data = kcc_pkg::KEY_SHIFT + 8'($urandom_range(2));
      end else begin
         op = kcc_pkg::OP_COMMAND;
         data = 8'($urandom_range(255));
      end
      send_item(op, data, 1'($urandom_range(1)), 1'($urandom_range(1)),
                1'($urandom_range(1)));
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_item      = '0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      send_item(kcc_pkg::OP_COMMAND, {kcc_pkg::GRP_RESET, 5'h00}, 1'b0, 1'b0, 1'b0);
      send_item(kcc_pkg::OP_COMMAND, 8'hff, 1'b1, 1'b1, 1'b1);
      send_item(kcc_pkg::OP_COMMAND, {kcc_pkg::GRP_LED_READ, 5'h00}, 1'b0, 1'b0, 1'b0);
      send_item(kcc_pkg::OP_COMMAND, {kcc_pkg::GRP_LED_SET, 5'h01}, 1'b0, 1'b0, 1'b0);
      send_item(kcc_pkg::OP_COMMAND, {kcc_pkg::GRP_LED_SET, 5'h0f}, 1'b0, 1'b0, 1'b0);
      send_item(kcc_pkg::OP_COMMAND, {kcc_pkg::GRP_LED_SET, 5'h1b}, 1'b0, 1'b0, 1'b0);
      send_item(kcc_pkg::OP_COMMAND, {kcc_pkg::GRP_LED_READ, 5'h1f}, 1'b1, 1'b1, 1'b1);
      send_item(kcc_pkg::OP_COMMAND, {kcc_pkg::GRP_LED_SET, 5'h1e}, 1'b0, 1'b0, 1'b0);
      send_item(kcc_pkg::OP_COMMAND, {kcc_pkg::GRP_LED_READ, 5'h00}, 1'b0, 1'b0, 1'b0);
      send_item(kcc_pkg::OP_COMMAND, {kcc_pkg::GRP_SW_READ, 5'h00}, 1'b0, 1'b0, 1'b0);
      send_item(kcc_pkg::OP_COMMAND, {kcc_pkg::GRP_SW_READ, 5'h1f}, 1'b1, 1'b1, 1'b1);
      send_item(kcc_pkg::OP_RELEASE, kcc_pkg::KEY_SHIFT, 1'b0, 1'b0, 1'b0);
      send_item(kcc_pkg::OP_RELEASE, kcc_pkg::KEY_CTRL, 1'b0, 1'b0, 1'b0);
      send_item(kcc_pkg::OP_RELEASE, kcc_pkg::KEY_GRAPH, 1'b0, 1'b0, 1'b0);
      send_item(kcc_pkg::OP_RELEASE, 8'h13, 1'b0, 1'b0, 1'b0);
      send_item(kcc_pkg::OP_RELEASE, 8'hff, 1'b1, 1'b1, 1'b1);
      send_item(kcc_pkg::OP_COMMAND, {kcc_pkg::GRP_ENABLE, 5'h00}, 1'b0, 1'b0, 1'b0);
      send_item(kcc_pkg::OP_RELEASE, kcc_pkg::KEY_SHIFT, 1'b0, 1'b0, 1'b0);
      send_item(kcc_pkg::OP_RELEASE, kcc_pkg::KEY_GRAPH, 1'b0, 1'b0, 1'b0);
      send_item(kcc_pkg::OP_COMMAND, {kcc_pkg::GRP_LED_READ, 5'h00}, 1'b0, 1'b0, 1'b0);
      send_item(kcc_pkg::OP_COMMAND, {kcc_pkg::GRP_ENABLE, 5'h01}, 1'b0, 1'b0, 1'b0);
      send_item(kcc_pkg::OP_COMMAND, {kcc_pkg::GRP_RPT_CTRL, 5'h00}, 1'b0, 1'b0, 1'b0);
      send_item(kcc_pkg::OP_COMMAND, {kcc_pkg::GRP_RPT_CTRL, 5'h1f}, 1'b0, 1'b0, 1'b0);
      send_item(kcc_pkg::OP_COMMAND, {kcc_pkg::GRP_RPT_TIME_0, 5'h00}, 1'b0, 1'b0, 1'b0);
      send_item(kcc_pkg::OP_COMMAND, {kcc_pkg::GRP_RPT_TIME_1, 5'h1f}, 1'b1, 1'b1, 1'b1);

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 57; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 57; end
            default: begin send_idle_pct = 29; rsp_stall_pct = 29; end
         endcase
         for (n = 0; n < 64; n++) send_random_item();
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (owed_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("summary: %0d items accepted, %0d reply bytes checked",
               accepted_items, checked_replies);
      $display("covered: all command groups, key releases enabled and disabled, four idle mixes");
      if (error_count == 0) begin
         $display("keyboard_command_controller_test: clean");
      end else begin
         $display("keyboard_command_controller_test: errors");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("timeout with %0d reply bytes still owed", owed_count);
      $display("keyboard_command_controller_test: errors");
      $finish;
   end

endmodule
